>>> rtl/particle_sensor_power_sequencer_unit_assert.svh
// assertion macros for the sequencer rtl
`ifndef PARTICLE_SENSOR_POWER_SEQUENCER_UNIT_ASSERT_SVH
`define PARTICLE_SENSOR_POWER_SEQUENCER_UNIT_ASSERT_SVH

// clocked check, masked while reset is high
`define PSPS_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define PSPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/psps_pkg.sv
// types, codes and reset values for the particle sensor power sequencer
package psps_pkg;

   // sequencer states
   localparam logic [3:0] ST_REQ_INFO     = 4'd0;
   localparam logic [3:0] ST_WAIT_INFO    = 4'd1;
   localparam logic [3:0] ST_REQ_SERIAL   = 4'd2;
   localparam logic [3:0] ST_WAIT_SERIAL  = 4'd3;
   localparam logic [3:0] ST_IDLE         = 4'd4;
   localparam logic [3:0] ST_LASER_ON     = 4'd5;
   localparam logic [3:0] ST_WAIT_LASER   = 4'd6;
   localparam logic [3:0] ST_FAN_ON       = 4'd7;
   localparam logic [3:0] ST_WAIT_FAN     = 4'd8;
   localparam logic [3:0] ST_READY        = 4'd9;
   localparam logic [3:0] ST_SAMPLE_START = 4'd10;
   localparam logic [3:0] ST_SAMPLE_WAIT  = 4'd11;
   localparam logic [3:0] ST_LASER_OFF    = 4'd12;
   localparam logic [3:0] ST_FAN_OFF      = 4'd13;

   // link commands
   localparam logic [2:0] CMD_NONE      = 3'd0;
   localparam logic [2:0] CMD_INFO      = 3'd1;
   localparam logic [2:0] CMD_SERIAL    = 3'd2;
   localparam logic [2:0] CMD_LASER_ON  = 3'd3;
   localparam logic [2:0] CMD_FAN_ON    = 3'd4;
   localparam logic [2:0] CMD_HISTOGRAM = 3'd5;
   localparam logic [2:0] CMD_LASER_OFF = 3'd6;
   localparam logic [2:0] CMD_FAN_OFF   = 3'd7;

   // request event codes
   localparam logic [2:0] EV_POLL    = 3'd0;
   localparam logic [2:0] EV_TICK    = 3'd1;
   localparam logic [2:0] EV_START   = 3'd2;
   localparam logic [2:0] EV_STOP    = 3'd3;
   localparam logic [2:0] EV_TRIGGER = 3'd4;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_LOW_POWER     = 3'd0;
   localparam logic [2:0] REG_INFO_WAIT     = 3'd1;
   localparam logic [2:0] REG_SERIAL_WAIT   = 3'd2;
   localparam logic [2:0] REG_LASER_WAIT    = 3'd3;
   localparam logic [2:0] REG_FAN_WAIT      = 3'd4;
   localparam logic [2:0] REG_LASER_THRESH  = 3'd5;

   localparam int CSR_ADDR_W = 5;

   localparam logic [15:0] RST_INFO_WAIT    = 16'd29;
   localparam logic [15:0] RST_SERIAL_WAIT  = 16'd29;
   localparam logic [15:0] RST_LASER_WAIT   = 16'd149;
   localparam logic [15:0] RST_FAN_WAIT     = 16'd249;
   localparam logic [15:0] RST_LASER_THRESH = 16'd300;

   localparam logic [7:0]  OLDER_MODEL_CHAR = 8'h32;
   localparam logic [15:0] COUNTER_MAX      = 16'hFFFF;

   typedef struct packed {
      logic        low_power;
      logic [15:0] info_wait_ticks;
      logic [15:0] serial_wait_ticks;
      logic [15:0] laser_wait_ticks;
      logic [15:0] fan_wait_ticks;
      logic [15:0] laser_threshold;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  seq_state;
      logic [15:0] wait_counter;
      logic        sampling_enabled;
      logic        older_model;
   } seq_type;

   typedef struct packed {
      logic [2:0]  func;
      logic        comm_ready;
      logic        cmd_accepted;
      logic        response_ready;
      logic [7:0]  model_char;
      logic [15:0] laser_status;
   } req_type;

endpackage

>>> rtl/psps_csr.sv
// apb register bank for the sequencer timing and mode settings
module psps_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [psps_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output psps_pkg::cfg_type                  cfg
);
   import psps_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign reg_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LOW_POWER:    cfg_in.low_power         = csr_pwdata[0];
            REG_INFO_WAIT:    cfg_in.info_wait_ticks   = csr_pwdata[15:0];
            REG_SERIAL_WAIT:  cfg_in.serial_wait_ticks = csr_pwdata[15:0];
            REG_LASER_WAIT:   cfg_in.laser_wait_ticks  = csr_pwdata[15:0];
            REG_FAN_WAIT:     cfg_in.fan_wait_ticks    = csr_pwdata[15:0];
            REG_LASER_THRESH: cfg_in.laser_threshold   = csr_pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_power         <= 1'b0;
         cfg_ff.info_wait_ticks   <= RST_INFO_WAIT;
         cfg_ff.serial_wait_ticks <= RST_SERIAL_WAIT;
         cfg_ff.laser_wait_ticks  <= RST_LASER_WAIT;
         cfg_ff.fan_wait_ticks    <= RST_FAN_WAIT;
         cfg_ff.laser_threshold   <= RST_LASER_THRESH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LOW_POWER:    csr_prdata = {31'd0, cfg_ff.low_power};
         REG_INFO_WAIT:    csr_prdata = {16'd0, cfg_ff.info_wait_ticks};
         REG_SERIAL_WAIT:  csr_prdata = {16'd0, cfg_ff.serial_wait_ticks};
         REG_LASER_WAIT:   csr_prdata = {16'd0, cfg_ff.laser_wait_ticks};
         REG_FAN_WAIT:     csr_prdata = {16'd0, cfg_ff.fan_wait_ticks};
         REG_LASER_THRESH: csr_prdata = {16'd0, cfg_ff.laser_threshold};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/psps_step.sv
// next-state and command logic for one sequencer event
module psps_step (
   input  psps_pkg::cfg_type  cfg,
   input  psps_pkg::seq_type  cur,
   input  psps_pkg::req_type  req,
   output psps_pkg::seq_type  nxt,
   output logic [2:0]         command,
   output logic               laser_fail
);
   import psps_pkg::*;

   always_comb begin
      nxt        = cur;
      command    = CMD_NONE;
      laser_fail = 1'b0;
      case (req.func)
         EV_POLL: begin
            case (cur.seq_state)
               ST_REQ_INFO: begin
                  if (req.comm_ready) begin
                     command = CMD_INFO;
                     if (req.cmd_accepted) begin
                        nxt.seq_state    = ST_WAIT_INFO;
                        nxt.wait_counter = 16'd0;
                     end
                  end
               end
               ST_WAIT_INFO: begin
                  if (cur.wait_counter > cfg.info_wait_ticks && req.response_ready) begin
                     if (req.model_char == OLDER_MODEL_CHAR) nxt.older_model = 1'b1;
                     nxt.seq_state = ST_REQ_SERIAL;
                  end
               end
               ST_REQ_SERIAL: begin
                  if (req.comm_ready) begin
                     command = CMD_SERIAL;
                     if (req.cmd_accepted) begin
                        nxt.seq_state    = ST_WAIT_SERIAL;
                        nxt.wait_counter = 16'd0;
                     end
                  end
               end
               ST_WAIT_SERIAL: begin
                  if (cur.wait_counter > cfg.serial_wait_ticks && req.response_ready)
                     nxt.seq_state = ST_IDLE;
               end
               ST_LASER_ON: begin
                  if (req.comm_ready) begin
                     command = CMD_LASER_ON;
                     if (req.cmd_accepted) begin
                        nxt.seq_state    = ST_WAIT_LASER;
                        nxt.wait_counter = 16'd0;
                     end
                  end
               end
               ST_WAIT_LASER: begin
                  if (cur.wait_counter > cfg.laser_wait_ticks) nxt.seq_state = ST_FAN_ON;
               end
               ST_FAN_ON: begin
                  if (req.comm_ready) begin
                     command = CMD_FAN_ON;
                     if (req.cmd_accepted) begin
                        nxt.seq_state    = ST_WAIT_FAN;
                        nxt.wait_counter = 16'd0;
                     end
                  end
               end
               ST_WAIT_FAN: begin
                  if (cur.wait_counter > cfg.fan_wait_ticks) begin
                     nxt.seq_state    = ST_READY;
                     nxt.wait_counter = 16'd0;
                  end
               end
               ST_SAMPLE_START: begin
                  if (req.comm_ready) begin
                     command = CMD_HISTOGRAM;
                     if (req.cmd_accepted) nxt.seq_state = ST_SAMPLE_WAIT;
                  end
               end
               ST_SAMPLE_WAIT: begin
                  if (req.response_ready) begin
                     if (req.laser_status < cfg.laser_threshold) begin
                        laser_fail    = 1'b1;
                        nxt.seq_state = ST_LASER_ON;
                     end else begin
                        nxt.seq_state = cfg.low_power ? ST_LASER_OFF : ST_READY;
                     end
                  end
               end
               ST_LASER_OFF: begin
                  if (req.comm_ready) begin
                     command = CMD_LASER_OFF;
                     if (req.cmd_accepted) nxt.seq_state = ST_FAN_OFF;
                  end
               end
               ST_FAN_OFF: begin
                  if (req.comm_ready) begin
                     command = CMD_FAN_OFF;
                     if (req.cmd_accepted) nxt.seq_state = ST_IDLE;
                  end
               end
               default: begin
                  nxt = cur;
               end
            endcase
         end
         EV_TICK: begin
            if (cur.wait_counter != COUNTER_MAX) nxt.wait_counter = cur.wait_counter + 16'd1;
         end
         EV_START: begin
            if (!cfg.low_power) nxt.seq_state = ST_LASER_ON;
            nxt.sampling_enabled = 1'b1;
         end
         EV_STOP: begin
            nxt.seq_state        = ST_LASER_OFF;
            nxt.sampling_enabled = 1'b0;
         end
         EV_TRIGGER: begin
            if (cur.sampling_enabled) begin
               if (cur.seq_state == ST_IDLE)
                  nxt.seq_state = cfg.low_power ? ST_LASER_ON : ST_SAMPLE_START;
               else if (cur.seq_state == ST_READY)
                  nxt.seq_state = ST_SAMPLE_START;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

>>> rtl/particle_sensor_power_sequencer_unit.sv
// top level of the particle sensor power sequencer
// a request accepted at a clock edge has its response registered at that same edge
// throughput: one request per cycle while rsp_tready is high; state and response register
//   load at the accepting edge, so back-to-back requests chain without gaps
// reset: synchronous, active high; clears sequencer state, flags, tick counter and
//   response valid, and loads the register defaults
`include "particle_sensor_power_sequencer_unit_assert.svh"

module particle_sensor_power_sequencer_unit (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata, lsb up: comm_ready, cmd_accepted, response_ready, model_char[7:0],
   //   laser_status[15:0], zero fill
   input  logic [31:0]                        req_tdata,
   // tuser: func[2:0]
   input  logic [2:0]                         req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata, lsb up: seq_state[3:0], command[2:0], laser_fail, older_model,
   //   sampling_on, zero fill
   output logic [15:0]                        rsp_tdata,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [psps_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import psps_pkg::*;

   cfg_type     cfg;
   req_type     req;
   seq_type     seq_ff;
   seq_type     seq_nxt;
   logic [2:0]  step_command;
   logic        step_fail;
   logic        req_fire;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_data_ff;

   assign csr_pready = 1'b1;

   psps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   // unpack the request
   assign req.func           = req_tuser;
   assign req.comm_ready     = req_tdata[0];
   assign req.cmd_accepted   = req_tdata[1];
   assign req.response_ready = req_tdata[2];
   assign req.model_char     = req_tdata[10:3];
   assign req.laser_status   = req_tdata[26:11];

   psps_step u_step (
      .cfg        (cfg),
      .cur        (seq_ff),
      .req        (req),
      .nxt        (seq_nxt),
      .command    (step_command),
      .laser_fail (step_fail)
   );

   // take a new request whenever the output slot is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // sequencer state advances only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff.seq_state        <= ST_REQ_INFO;
         seq_ff.wait_counter     <= 16'd0;
         seq_ff.sampling_enabled <= 1'b0;
         seq_ff.older_model      <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         if (req_fire) seq_ff <= seq_nxt;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {6'd0, seq_nxt.sampling_enabled, seq_nxt.older_model, step_fail,
                         step_command, seq_nxt.seq_state};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a full, stalled output slot must hold off new requests
   `PSPS_ASSERT_ALWAYS(a_stall_blocks_req, clock,
      (rsp_valid_ff && !rsp_tready) |-> !req_tready, "request taken into a stalled slot")

   // every accepted request lands in the output slot
   `PSPS_ASSERT_RST(a_fire_gives_rsp, clock, reset,
      req_fire |=> rsp_valid_ff, "accepted request produced no response")

   // only a poll step offers a command
   `PSPS_ASSERT_RST(a_cmd_only_on_poll, clock, reset,
      (req_fire && req_tuser != EV_POLL) |=> (rsp_data_ff[6:4] == CMD_NONE),
      "command offered on a non-poll event")

   // a tick below the top steps the counter by one
   `PSPS_ASSERT_RST(a_tick_counts, clock, reset,
      (req_fire && req_tuser == EV_TICK && seq_ff.wait_counter != COUNTER_MAX)
         |=> (seq_ff.wait_counter == $past(seq_ff.wait_counter) + 16'd1),
      "tick did not advance the wait counter")

   // stop always clears sampling
   `PSPS_ASSERT_RST(a_stop_clears, clock, reset,
      (req_fire && req_tuser == EV_STOP) |=> !seq_ff.sampling_enabled,
      "stop left sampling enabled")

endmodule
